// File: design/adaptive_traffic_light_controller_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the traffic light controller
// Shared property templates used by the core's checks.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_CORE_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ATLC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("atlc check failed");

// antecedent implies consequent in the next cycle
`define ATLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("atlc check failed");

`endif

// File: design/atlc_pkg.sv
// ----------------------------------------------------------------------------
// atlc_pkg
// Types, codes and constants of the traffic light controller.
// ----------------------------------------------------------------------------
package atlc_pkg;

  localparam int NUM_ROADS_DEFAULT = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int TIME_W     = 8;
  localparam int CNT_W      = 8;
  localparam int CAM_W      = 4;
  localparam int OUT_ROADS  = 4;

  localparam logic [CNT_W-1:0] DENS_LOW_MIN  = 8'd3;
  localparam logic [CNT_W-1:0] DENS_LOW_MAX  = 8'd4;
  localparam logic [CNT_W-1:0] DENS_MED_MAX  = 8'd6;
  localparam logic [CNT_W-1:0] DENS_HIGH_MAX = 8'd9;

  localparam logic [TIME_W-1:0] GREEN_OFF_RST  = 8'd5;
  localparam logic [TIME_W-1:0] GREEN_LOW_RST  = 8'd8;
  localparam logic [TIME_W-1:0] GREEN_MED_RST  = 8'd12;
  localparam logic [TIME_W-1:0] GREEN_HIGH_RST = 8'd18;
  localparam logic [TIME_W-1:0] GREEN_VHI_RST  = 8'd25;
  localparam logic [TIME_W-1:0] YELLOW_RST     = 8'd3;
  localparam logic              ES_EN_RST      = 1'b1;
  localparam logic [CAM_W-1:0]  CAM_MASK_RST   = 4'd0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_COUNT = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } atlc_op_e;

  typedef enum logic [1:0] {
    LIGHT_OFF    = 2'd0,
    LIGHT_RED    = 2'd1,
    LIGHT_YELLOW = 2'd2,
    LIGHT_GREEN  = 2'd3
  } atlc_light_e;

  typedef enum logic [2:0] {
    DENS_OFF       = 3'd0,
    DENS_LOW       = 3'd1,
    DENS_MEDIUM    = 3'd2,
    DENS_HIGH      = 3'd3,
    DENS_VERY_HIGH = 3'd4
  } atlc_density_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREEN_OFF    = 4'd0,
    REG_GREEN_LOW    = 4'd1,
    REG_GREEN_MEDIUM = 4'd2,
    REG_GREEN_HIGH   = 4'd3,
    REG_GREEN_VHIGH  = 4'd4,
    REG_YELLOW       = 4'd5,
    REG_ES_ENABLE    = 4'd6,
    REG_CAMERA_MASK  = 4'd7
  } atlc_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] green_off;
    logic [TIME_W-1:0] green_low;
    logic [TIME_W-1:0] green_medium;
    logic [TIME_W-1:0] green_high;
    logic [TIME_W-1:0] green_very_high;
    logic [TIME_W-1:0] yellow_time;
    logic              es_enable;
    logic [CAM_W-1:0]  camera_mask;
  } atlc_cfg_t;

  typedef struct packed {
    atlc_op_e         opcode;
    logic [1:0]       road;
    logic [CNT_W-1:0] vehicle_count;
  } atlc_item_t;

  typedef struct packed {
    logic [1:0]        light_road0;
    logic [1:0]        light_road1;
    logic [1:0]        light_road2;
    logic [1:0]        light_road3;
    logic [1:0]        served_road;
    logic [TIME_W-1:0] seconds_left;
    logic              saving_active;
  } atlc_result_t;

  typedef struct packed {
    logic running;
    logic timer_on;
  } atlc_status_t;

  function automatic atlc_density_e density_of(logic [CNT_W-1:0] n);
    atlc_density_e d;
    if (n < DENS_LOW_MIN) begin
      d = DENS_OFF;
    end else if (n <= DENS_LOW_MAX) begin
      d = DENS_LOW;
    end else if (n <= DENS_MED_MAX) begin
      d = DENS_MEDIUM;
    end else if (n <= DENS_HIGH_MAX) begin
      d = DENS_HIGH;
    end else begin
      d = DENS_VERY_HIGH;
    end
    return d;
  endfunction

endpackage

// File: design/atlc_if.sv
// ----------------------------------------------------------------------------
// atlc interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface atlc_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [1:0]                 road;
  logic [atlc_pkg::CNT_W-1:0] vehicle_count;

  modport source (output valid, output opcode, output road, output vehicle_count,
                  input ready);
  modport sink (input valid, input opcode, input road, input vehicle_count,
                output ready);
endinterface

interface atlc_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  light_road0;
  logic [1:0]                  light_road1;
  logic [1:0]                  light_road2;
  logic [1:0]                  light_road3;
  logic [1:0]                  served_road;
  logic [atlc_pkg::TIME_W-1:0] seconds_left;
  logic                        saving_active;

  modport source (output valid, output light_road0, output light_road1,
                  output light_road2, output light_road3, output served_road,
                  output seconds_left, output saving_active, input ready);
  modport sink (input valid, input light_road0, input light_road1,
                input light_road2, input light_road3, input served_road,
                input seconds_left, input saving_active, output ready);
endinterface

interface atlc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [atlc_pkg::CFG_IDX_W-1:0]  index;
  logic [atlc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/atlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// atlc_cfg_regs
// Configuration register file: green times, yellow time, saving, cameras.
// ----------------------------------------------------------------------------
module atlc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  atlc_cfg_if.sink            cfg_i,
  output atlc_pkg::atlc_cfg_t cfg_o
);

  atlc_pkg::atlc_cfg_t cfg_q;
  logic                wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_off       <= atlc_pkg::GREEN_OFF_RST;
      cfg_q.green_low       <= atlc_pkg::GREEN_LOW_RST;
      cfg_q.green_medium    <= atlc_pkg::GREEN_MED_RST;
      cfg_q.green_high      <= atlc_pkg::GREEN_HIGH_RST;
      cfg_q.green_very_high <= atlc_pkg::GREEN_VHI_RST;
      cfg_q.yellow_time     <= atlc_pkg::YELLOW_RST;
      cfg_q.es_enable       <= atlc_pkg::ES_EN_RST;
      cfg_q.camera_mask     <= atlc_pkg::CAM_MASK_RST;
    end else if (wr) begin
      case (cfg_i.index)
        atlc_pkg::REG_GREEN_OFF:    cfg_q.green_off       <= cfg_i.data;
        atlc_pkg::REG_GREEN_LOW:    cfg_q.green_low       <= cfg_i.data;
        atlc_pkg::REG_GREEN_MEDIUM: cfg_q.green_medium    <= cfg_i.data;
        atlc_pkg::REG_GREEN_HIGH:   cfg_q.green_high      <= cfg_i.data;
        atlc_pkg::REG_GREEN_VHIGH:  cfg_q.green_very_high <= cfg_i.data;
        atlc_pkg::REG_YELLOW:       cfg_q.yellow_time     <= cfg_i.data;
        atlc_pkg::REG_ES_ENABLE:    cfg_q.es_enable       <= cfg_i.data[0];
        atlc_pkg::REG_CAMERA_MASK:  cfg_q.camera_mask     <= cfg_i.data[atlc_pkg::CAM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/atlc_in_reg.sv
// ----------------------------------------------------------------------------
// atlc_in_reg
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module atlc_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  atlc_item_if.sink            item_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output atlc_pkg::atlc_item_t item_o
);

  logic                 valid_q;
  atlc_pkg::atlc_item_t item_q;
  logic                 take;

  assign item_i.ready = !valid_q || pop_i;
  assign take         = item_i.valid && item_i.ready;
  assign valid_o      = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.opcode        <= atlc_pkg::atlc_op_e'(item_i.opcode);
      item_q.road          <= item_i.road;
      item_q.vehicle_count <= item_i.vehicle_count;
    end
  end

endmodule

// File: design/atlc_ctrl.sv
// ----------------------------------------------------------------------------
// atlc_ctrl
// Controller state and per-item next-state logic, one item per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module atlc_ctrl #(
  parameter int NUM_ROADS = atlc_pkg::NUM_ROADS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  atlc_pkg::atlc_item_t   item_i,
  input  atlc_pkg::atlc_cfg_t    cfg_i,
  output atlc_pkg::atlc_result_t result_o,
  output atlc_pkg::atlc_status_t status_o
);

  localparam int RW   = (NUM_ROADS > 1) ? $clog2(NUM_ROADS) : 1;
  localparam int NCAM = (NUM_ROADS < atlc_pkg::CAM_W) ? NUM_ROADS : atlc_pkg::CAM_W;
  localparam int NP   = (NUM_ROADS > atlc_pkg::OUT_ROADS) ? NUM_ROADS : atlc_pkg::OUT_ROADS;
  localparam logic [RW-1:0] LAST_ROAD = RW'(NUM_ROADS - 1);

  typedef atlc_pkg::atlc_light_e   [NUM_ROADS-1:0] lights_t;
  typedef logic [NUM_ROADS-1:0][atlc_pkg::CNT_W-1:0] counts_t;
  typedef atlc_pkg::atlc_density_e [NUM_ROADS-1:0] dens_t;

  logic                        run_q, run_d;
  logic [RW-1:0]               cur_q, cur_d;
  logic                        yel_q, yel_d;
  logic                        tmr_q, tmr_d;
  logic [atlc_pkg::TIME_W-1:0] rem_q, rem_d;
  logic                        sav_q, sav_d;
  lights_t                     lights_q, lights_d;
  counts_t                     counts_q, counts_d;
  dens_t                       dens_q, dens_d;

  logic                        req_green;
  logic                        count_run;
  logic                        empty;
  logic [RW-1:0]               road_idx;
  logic [NP-1:0][1:0]          lt_pad;

  function automatic lights_t green_pattern(logic [RW-1:0] cur);
    lights_t l;
    for (int i = 0; i < NUM_ROADS; i++) begin
      l[i] = (RW'(i) == cur) ? atlc_pkg::LIGHT_GREEN : atlc_pkg::LIGHT_RED;
    end
    return l;
  endfunction

  function automatic logic [atlc_pkg::TIME_W-1:0] green_for(atlc_pkg::atlc_density_e d,
                                                           atlc_pkg::atlc_cfg_t c);
    logic [atlc_pkg::TIME_W-1:0] t;
    case (d)
      atlc_pkg::DENS_OFF:    t = c.green_off;
      atlc_pkg::DENS_LOW:    t = c.green_low;
      atlc_pkg::DENS_MEDIUM: t = c.green_medium;
      atlc_pkg::DENS_HIGH:   t = c.green_high;
      default:               t = c.green_very_high;
    endcase
    return t;
  endfunction

  assign road_idx = RW'(item_i.road);

  always_comb begin
    run_d     = run_q;
    cur_d     = cur_q;
    yel_d     = yel_q;
    tmr_d     = tmr_q;
    rem_d     = rem_q;
    sav_d     = sav_q;
    lights_d  = lights_q;
    counts_d  = counts_q;
    dens_d    = dens_q;
    req_green = 1'b0;
    count_run = 1'b0;
    empty     = 1'b1;

    case (item_i.opcode)
      atlc_pkg::OP_TICK: begin
        if (tmr_q) begin
          if (!run_q || sav_q) begin
            tmr_d = 1'b0;
          end else begin
            if (rem_q != '0) begin
              rem_d = rem_q - 1'b1;
            end
            if (rem_d == '0) begin
              tmr_d = 1'b0;
              if (!yel_q) begin
                lights_d[cur_q] = atlc_pkg::LIGHT_YELLOW;
                yel_d           = 1'b1;
                rem_d           = cfg_i.yellow_time;
                tmr_d           = 1'b1;
              end else begin
                yel_d           = 1'b0;
                lights_d[cur_q] = atlc_pkg::LIGHT_RED;
                cur_d           = (cur_q == LAST_ROAD) ? '0 : cur_q + 1'b1;
                req_green       = 1'b1;
              end
            end
          end
        end
      end
      atlc_pkg::OP_COUNT: begin
        if (32'(item_i.road) < NUM_ROADS) begin
          counts_d[road_idx] = item_i.vehicle_count;
          dens_d[road_idx]   = atlc_pkg::density_of(item_i.vehicle_count);
          if (run_q) begin
            count_run = 1'b1;
            if (!cfg_i.es_enable) begin
              if (sav_q) begin
                sav_d     = 1'b0;
                req_green = 1'b1;
              end
            end else begin
              for (int i = 0; i < NCAM; i++) begin
                if (cfg_i.camera_mask[i] && counts_d[i] != '0) begin
                  empty = 1'b0;
                end
              end
              if (empty && !sav_q) begin
                sav_d    = 1'b1;
                tmr_d    = 1'b0;
                yel_d    = 1'b0;
                lights_d = {NUM_ROADS{atlc_pkg::LIGHT_OFF}};
              end else if (!empty && sav_q) begin
                sav_d     = 1'b0;
                req_green = 1'b1;
              end
            end
          end
        end
      end
      atlc_pkg::OP_START: begin
        if (!run_q) begin
          run_d     = 1'b1;
          cur_d     = '0;
          yel_d     = 1'b0;
          rem_d     = '0;
          req_green = 1'b1;
        end
      end
      default: begin
        if (run_q) begin
          run_d    = 1'b0;
          tmr_d    = 1'b0;
          lights_d = cfg_i.es_enable ? {NUM_ROADS{atlc_pkg::LIGHT_OFF}}
                                     : {NUM_ROADS{atlc_pkg::LIGHT_RED}};
        end
      end
    endcase

    if (req_green && run_d && !sav_d && !yel_d && !tmr_d) begin
      lights_d = green_pattern(cur_d);
      rem_d    = green_for(dens_d[cur_d], cfg_i);
      tmr_d    = 1'b1;
    end

    // vehicles showed up on the dark served road
    if (count_run && !sav_d && lights_d[cur_d] == atlc_pkg::LIGHT_OFF &&
        counts_d[cur_d] != '0 && run_d && !yel_d && !tmr_d) begin
      lights_d = green_pattern(cur_d);
      rem_d    = green_for(dens_d[cur_d], cfg_i);
      tmr_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      cur_q    <= '0;
      yel_q    <= 1'b0;
      tmr_q    <= 1'b0;
      rem_q    <= '0;
      sav_q    <= 1'b0;
      lights_q <= {NUM_ROADS{atlc_pkg::LIGHT_OFF}};
      counts_q <= '0;
      dens_q   <= {NUM_ROADS{atlc_pkg::DENS_OFF}};
    end else if (fire_i) begin
      run_q    <= run_d;
      cur_q    <= cur_d;
      yel_q    <= yel_d;
      tmr_q    <= tmr_d;
      rem_q    <= rem_d;
      sav_q    <= sav_d;
      lights_q <= lights_d;
      counts_q <= counts_d;
      dens_q   <= dens_d;
    end
  end

  assign lt_pad = (2 * NP)'(lights_d);

  always_comb begin
    result_o.light_road0   = lt_pad[0];
    result_o.light_road1   = lt_pad[1];
    result_o.light_road2   = lt_pad[2];
    result_o.light_road3   = lt_pad[3];
    result_o.served_road   = 2'(cur_d);
    result_o.seconds_left  = rem_d;
    result_o.saving_active = sav_d;
  end

  assign status_o.running  = run_q;
  assign status_o.timer_on = tmr_q;

endmodule

// File: design/atlc_out_reg.sv
// ----------------------------------------------------------------------------
// atlc_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module atlc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  atlc_pkg::atlc_result_t result_i,
  output logic                   free_o,
  atlc_result_if.source          result_o
);

  logic                   valid_q;
  atlc_pkg::atlc_result_t data_q;

  assign free_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.light_road0   = data_q.light_road0;
  assign result_o.light_road1   = data_q.light_road1;
  assign result_o.light_road2   = data_q.light_road2;
  assign result_o.light_road3   = data_q.light_road3;
  assign result_o.served_road   = data_q.served_road;
  assign result_o.seconds_left  = data_q.seconds_left;
  assign result_o.saving_active = data_q.saving_active;

endmodule

// File: design/adaptive_traffic_light_controller_core.sv
// ----------------------------------------------------------------------------
// adaptive_traffic_light_controller_core: density-adaptive four-way signal
// Path: item captured in the input register, next state computed, result loaded
// into the result register once it is free; one item per cycle while results drain.
// Rate set by the combinational next-state logic between in and out registers.
// Async active-low reset: stopped, lights off, counts zero, defaults loaded.
// ----------------------------------------------------------------------------
`include "adaptive_traffic_light_controller_core_defines.svh"

module adaptive_traffic_light_controller_core #(
  parameter int NUM_ROADS = atlc_pkg::NUM_ROADS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  atlc_cfg_if.sink      cfg_i,
  atlc_item_if.sink     item_i,
  atlc_result_if.source result_o
);

  atlc_pkg::atlc_cfg_t    cfg;
  atlc_pkg::atlc_item_t   item;
  atlc_pkg::atlc_result_t result;
  atlc_pkg::atlc_status_t status;
  logic                   item_valid;
  logic                   out_free;
  logic                   fire;

  assign fire = item_valid && out_free;

  atlc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  atlc_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .pop_i   (fire),
    .valid_o (item_valid),
    .item_o  (item)
  );

  atlc_ctrl #(
    .NUM_ROADS (NUM_ROADS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result),
    .status_o (status)
  );

  atlc_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .free_o   (out_free),
    .result_o (result_o)
  );

  `ATLC_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, fire, result_o.valid)
  `ATLC_ASSERT_NOW(a_stopped_no_timer, clk_i, rst_ni, !status.running, !status.timer_on)
  `ATLC_ASSERT_NEXT(a_held_item_stays, clk_i, rst_ni, item_valid && !fire, item_valid)

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: adaptive traffic light controller testbench
// Sends tick, count, start and stop events with random gaps against a
// stalling result sink, predicts the light state after every event and
// checks each result in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
  import atlc_pkg::*;

  localparam int ROADS       = NUM_ROADS_DEFAULT;
  localparam int CYCLE_CAP   = 600000;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 8;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hf;

  class light_scoreboard;
    atlc_cfg_t         cfg;
    logic              running, yellow, timer_on, saving;
    logic [1:0]        cur_road;
    logic [TIME_W-1:0] secs;
    atlc_light_e       lights [ROADS];
    logic [CNT_W-1:0]  counts [ROADS];
    atlc_density_e     dens [ROADS];
    atlc_result_t      expected_q [$];
    int                errors;

    function new();
      cfg = '{GREEN_OFF_RST, GREEN_LOW_RST, GREEN_MED_RST, GREEN_HIGH_RST,
              GREEN_VHI_RST, YELLOW_RST, ES_EN_RST, CAM_MASK_RST};
      running  = 1'b0;
      yellow   = 1'b0;
      timer_on = 1'b0;
      saving   = 1'b0;
      cur_road = '0;
      secs     = '0;
      errors   = 0;
      for (int i = 0; i < ROADS; i++) begin
        lights[i] = LIGHT_OFF;
        counts[i] = '0;
        dens[i]   = DENS_OFF;
      end
    endfunction

    function atlc_density_e class_of(logic [CNT_W-1:0] n);
      if (n < 8'd3) return DENS_OFF;
      if (n <= 8'd4) return DENS_LOW;
      if (n <= 8'd6) return DENS_MEDIUM;
      if (n <= 8'd9) return DENS_HIGH;
      return DENS_VERY_HIGH;
    endfunction

    function logic [TIME_W-1:0] green_for(atlc_density_e d);
      case (d)
        DENS_OFF:    return cfg.green_off;
        DENS_LOW:    return cfg.green_low;
        DENS_MEDIUM: return cfg.green_medium;
        DENS_HIGH:   return cfg.green_high;
        default:     return cfg.green_very_high;
      endcase
    endfunction

    function void all_lights(atlc_light_e v);
      for (int i = 0; i < ROADS; i++) lights[i] = v;
    endfunction

    function void start_green();
      if (!running || saving || yellow || timer_on) return;
      for (int i = 0; i < ROADS; i++) begin
        if (i == cur_road) lights[i] = LIGHT_GREEN;
        else lights[i] = LIGHT_RED;
      end
      secs     = green_for(dens[cur_road]);
      timer_on = 1'b1;
    endfunction

    function void advance_phase();
      if (saving) return;
      if (!yellow) begin
        lights[cur_road] = LIGHT_YELLOW;
        yellow   = 1'b1;
        secs     = cfg.yellow_time;
        timer_on = 1'b1;
      end else begin
        yellow = 1'b0;
        lights[cur_road] = LIGHT_RED;
        cur_road = cur_road + 2'd1;
        start_green();
      end
    endfunction

    function void update_saving();
      logic empty;
      empty = 1'b1;
      if (!cfg.es_enable) begin
        if (saving) begin
          saving = 1'b0;
          start_green();
        end
        return;
      end
      for (int i = 0; i < ROADS; i++) begin
        if (cfg.camera_mask[i] && counts[i] != 0) empty = 1'b0;
      end
      if (empty && !saving) begin
        saving   = 1'b1;
        timer_on = 1'b0;
        yellow   = 1'b0;
        all_lights(LIGHT_OFF);
      end else if (!empty && saving) begin
        saving = 1'b0;
        start_green();
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GREEN_OFF:    cfg.green_off       = data;
        REG_GREEN_LOW:    cfg.green_low       = data;
        REG_GREEN_MEDIUM: cfg.green_medium    = data;
        REG_GREEN_HIGH:   cfg.green_high      = data;
        REG_GREEN_VHIGH:  cfg.green_very_high = data;
        REG_YELLOW:       cfg.yellow_time     = data;
        REG_ES_ENABLE:    cfg.es_enable       = data[0];
        REG_CAMERA_MASK:  cfg.camera_mask     = data[CAM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_event(atlc_op_e op, logic [1:0] road, logic [CNT_W-1:0] cnt);
      atlc_result_t want;
      case (op)
        OP_TICK: begin
          if (timer_on) begin
            if (!running || saving) begin
              timer_on = 1'b0;
            end else begin
              if (secs > 0) secs = secs - 1'b1;
              if (secs == 0) begin
                timer_on = 1'b0;
                advance_phase();
              end
            end
          end
        end
        OP_COUNT: begin
          counts[road] = cnt;
          dens[road]   = class_of(cnt);
          if (running) begin
            update_saving();
            if (!saving && lights[cur_road] == LIGHT_OFF && counts[cur_road] != 0)
              start_green();
          end
        end
        OP_START: begin
          if (!running) begin
            running  = 1'b1;
            cur_road = '0;
            yellow   = 1'b0;
            secs     = '0;
            start_green();
          end
        end
        default: begin
          if (running) begin
            running  = 1'b0;
            timer_on = 1'b0;
            if (cfg.es_enable) all_lights(LIGHT_OFF);
            else all_lights(LIGHT_RED);
          end
        end
      endcase
      want.light_road0   = lights[0];
      want.light_road1   = lights[1];
      want.light_road2   = lights[2];
      want.light_road3   = lights[3];
      want.served_road   = cur_road;
      want.seconds_left  = secs;
      want.saving_active = saving;
      expected_q.push_back(want);
    endfunction

    function void check_lights(atlc_result_t got);
      atlc_result_t want;
      logic [7:0]   w [7];
      logic [7:0]   g [7];
      string        tag [7];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      w = '{8'(want.light_road0), 8'(want.light_road1), 8'(want.light_road2),
            8'(want.light_road3), 8'(want.served_road), want.seconds_left,
            8'(want.saving_active)};
      g = '{8'(got.light_road0), 8'(got.light_road1), 8'(got.light_road2),
            8'(got.light_road3), 8'(got.served_road), got.seconds_left,
            8'(got.saving_active)};
      tag = '{"light_road0", "light_road1", "light_road2", "light_road3",
              "served_road", "seconds_left", "saving_active"};
      for (int i = 0; i < 7; i++) begin
        if (w[i] !== g[i]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, tag[i], w[i], g[i]);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_req;
  logic no_idle;
  int   cycle_cnt;
  light_scoreboard sb;

  atlc_item_if   item_bus ();
  atlc_result_if light_bus ();
  atlc_cfg_if    cfg_bus ();

  adaptive_traffic_light_controller_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (light_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL adaptive_traffic_light_controller_core");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, long hold-off on request
  initial begin
    int   n;
    logic lvl;
    lvl = 1'b0;
    light_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        lvl = 1'b0;
        n = HOLD_LEN;
      end else if (no_idle || !lvl) begin
        lvl = 1'b1;
        n = no_idle ? 1 : $urandom_range(1, 30);
      end else begin
        lvl = 1'b0;
        n = idle_len();
        if (n == 0) n = 1;
      end
      light_bus.ready <= lvl;
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && item_bus.valid && item_bus.ready)
      sb.note_event(atlc_op_e'(item_bus.opcode), item_bus.road, item_bus.vehicle_count);
  end

  always @(posedge clk_i) begin
    if (rst_ni && light_bus.valid && light_bus.ready)
      sb.check_lights(atlc_result_t'({light_bus.light_road0, light_bus.light_road1,
                                      light_bus.light_road2, light_bus.light_road3,
                                      light_bus.served_road, light_bus.seconds_left,
                                      light_bus.saving_active}));
  end

  task automatic send_event(atlc_op_e op, logic [1:0] road, logic [CNT_W-1:0] cnt);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid         <= 1'b1;
    item_bus.opcode        <= op;
    item_bus.road          <= road;
    item_bus.vehicle_count <= cnt;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
  endtask

  task automatic send_random();
    int               r;
    int               start_pct;
    atlc_op_e         op;
    logic [CNT_W-1:0] cnt;
    start_pct = sb.running ? 3 : 25;
    r = $urandom_range(0, 99);
    if (r < start_pct) op = OP_START;
    else if (r < start_pct + 4) op = OP_STOP;
    else if (r < start_pct + 32) op = OP_COUNT;
    else op = OP_TICK;
    r = $urandom_range(0, 99);
    if (r < 15) cnt = '0;
    else if (r < 65) cnt = CNT_W'($urandom_range(0, 12));
    else cnt = CNT_W'($urandom_range(0, 255));
    send_event(op, 2'($urandom_range(0, 3)), cnt);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [8], input bit extra);
    atlc_reg_e r;
    r = REG_GREEN_OFF;
    repeat (8) begin
      write_reg(r, vals[r]);
      r = r.next();
    end
    if (extra) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] vals [8];
    sb       = new();
    hold_req = 1'b0;
    no_idle  = 1'b0;
    rst_ni                 <= 1'b0;
    item_bus.valid         <= 1'b0;
    item_bus.opcode        <= OP_TICK;
    item_bus.road          <= '0;
    item_bus.vehicle_count <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= '0;
    cfg_bus.data           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no cameras, so any report while running enters saving
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_STOP, 2'd0, 8'd0);
    send_event(OP_COUNT, 2'd0, 8'd255);
    send_event(OP_START, 2'd0, 8'd0);
    send_event(OP_START, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_COUNT, 2'd1, 8'd2);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_STOP, 2'd0, 8'd0);
    send_event(OP_START, 2'd0, 8'd0);
    drain();

    // zero-length phases, saving disabled, all cameras
    foreach (vals[i]) vals[i] = '0;
    vals[REG_CAMERA_MASK] = 8'h0f;
    program_regs(vals, 1'b0);
    send_event(OP_COUNT, 2'd2, 8'd3);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_COUNT, 2'd3, 8'd4);
    send_event(OP_COUNT, 2'd1, 8'd5);
    send_event(OP_COUNT, 2'd0, 8'd6);
    send_event(OP_COUNT, 2'd2, 8'd7);
    send_event(OP_COUNT, 2'd3, 8'd9);
    send_event(OP_COUNT, 2'd1, 8'd10);
    send_event(OP_COUNT, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);
    send_event(OP_STOP, 2'd0, 8'd0);
    send_event(OP_TICK, 2'd0, 8'd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          for (int r = REG_GREEN_OFF; r <= REG_GREEN_VHIGH; r++)
            vals[r] = CFG_DATA_W'($urandom_range(0, 6));
          vals[REG_YELLOW]      = CFG_DATA_W'($urandom_range(0, 3));
          vals[REG_ES_ENABLE]   = 8'd1;
          vals[REG_CAMERA_MASK] = 8'h0f;
        end
        1: foreach (vals[i]) vals[i] = 8'h00;
        2: foreach (vals[i]) vals[i] = 8'hff;
        3: foreach (vals[i]) vals[i] = CFG_DATA_W'($urandom_range(0, 255));
        4: begin
          for (int r = REG_GREEN_OFF; r <= REG_GREEN_VHIGH; r++)
            vals[r] = CFG_DATA_W'($urandom_range(0, 8));
          vals[REG_YELLOW]      = CFG_DATA_W'($urandom_range(0, 4));
          vals[REG_ES_ENABLE]   = CFG_DATA_W'($urandom_range(0, 255));
          vals[REG_CAMERA_MASK] = CFG_DATA_W'($urandom_range(0, 255));
        end
        5: begin
          for (int r = REG_GREEN_OFF; r <= REG_GREEN_VHIGH; r++)
            vals[r] = CFG_DATA_W'($urandom_range(0, 3));
          vals[REG_YELLOW]      = CFG_DATA_W'($urandom_range(0, 2));
          vals[REG_ES_ENABLE]   = 8'd1;
          vals[REG_CAMERA_MASK] = CFG_DATA_W'($urandom_range(1, 15));
        end
        default: begin
          for (int r = REG_GREEN_OFF; r <= REG_GREEN_VHIGH; r++)
            vals[r] = CFG_DATA_W'($urandom_range(0, 10));
          vals[REG_YELLOW]      = 8'd1;
          vals[REG_ES_ENABLE]   = 8'd0;
          vals[REG_CAMERA_MASK] = 8'h0f;
        end
      endcase
      program_regs(vals, p == 5);
      if (p == 0) hold_req = 1'b1;
      no_idle = (p == 4);
      repeat (PHASE_ITEMS) send_random();
    end
    no_idle = 1'b0;
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS adaptive_traffic_light_controller_core");
    end else begin
      $display("FAIL adaptive_traffic_light_controller_core");
    end
    $finish;
  end

endmodule
